// ----- src/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Screen geometry, cell codes, request and result structs, address helpers.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);

  // Character and attribute codes
  localparam logic [7:0]  CHAR_NEWLINE    = 8'h0A;
  localparam logic [7:0]  CHAR_SPACE      = 8'h20;
  localparam logic [7:0]  CHAR_MARK       = 8'h23;
  localparam logic [7:0]  ATTR_LIGHT_BLUE = 8'h09;
  localparam logic [7:0]  ATTR_WHITE      = 8'h0F;
  localparam logic [7:0]  COLOR_RESET     = 8'h07;
  localparam logic [15:0] CELL_RESET      = 16'h0720;

  // Operation modes
  localparam logic [1:0] MODE_PUT_CHAR  = 2'd0;
  localparam logic [1:0] MODE_PUT_ENTRY = 2'd1;
  localparam logic [1:0] MODE_MARKER    = 2'd2;
  localparam logic [1:0] MODE_READ      = 2'd3;

  // Request to the cell memory
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       wdata;
  } mem_req_t;

  // Result handoff from the sequencer to the output register
  typedef struct packed {
    logic       load;
    logic       use_rd;
    logic [6:0] cursor_column;
    logic [4:0] cursor_row;
    logic       did_scroll;
  } res_t;

  // Map a logical row through the circular top offset
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                input logic [ROW_W-1:0] y);
    logic [ROW_W:0] sum;
    sum = {1'b0, top} + {1'b0, y};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  // Linear cell address of a physical row and column
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] x);
    return ADDR_W'(prow) * ADDR_W'(COLS) + ADDR_W'(x);
  endfunction

endpackage

// ----- src/tcw_cell_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_cell_ram: character cell memory
// Single port synchronous RAM, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module tcw_cell_ram (
  input  logic              clk,
  input  tcw_pkg::mem_req_t req,
  output logic [15:0]       rdata
);
  import tcw_pkg::*;

  logic [15:0] mem [CELLS];

  // Write or read one cell
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// ----- src/tcw_seq.sv -----
// ----------------------------------------------------------------------------
// tcw_seq: console sequencer
// Holds cursor, top offset and color; drives the cell memory, the clearing
// sweep after reset and the bottom row fill on scroll.
// ----------------------------------------------------------------------------
module tcw_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        mode,
  input  logic [7:0]        character,
  input  logic [7:0]        entry_color,
  input  logic [6:0]        col_x,
  input  logic [4:0]        row_y,
  input  logic              show,
  input  logic              out_free,
  output tcw_pkg::mem_req_t req,
  output tcw_pkg::res_t     res
);
  import tcw_pkg::*;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_FILL} state_t;

  state_t            state;
  state_t            state_next;
  logic [COL_W-1:0]  cur_col;
  logic [COL_W-1:0]  cur_col_next;
  logic [ROW_W-1:0]  cur_row;
  logic [ROW_W-1:0]  cur_row_next;
  logic [ROW_W-1:0]  top;
  logic [ROW_W-1:0]  top_next;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] cnt_next;
  logic [ADDR_W-1:0] fill_addr;
  logic [ADDR_W-1:0] fill_addr_next;
  logic              rd_ok;
  logic              rd_ok_next;
  logic [7:0]        text_color;

  logic              accept;
  logic              xy_ok;
  logic [ADDR_W-1:0] xy_addr;
  logic [ADDR_W-1:0] cur_addr;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic              wrap;
  logic              scroll;

  assign in_ready = (state == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // Decode positions and cursor motion
  always_comb begin
    xy_ok    = (int'(col_x) < COLS) && (int'(row_y) < ROWS);
    xy_addr  = cell_addr(phys_row(top, ROW_W'(row_y)), COL_W'(col_x));
    cur_addr = cell_addr(phys_row(top, cur_row), cur_col);
    col_inc  = {1'b0, cur_col} + 1'b1;
    row_inc  = {1'b0, cur_row} + 1'b1;
    wrap     = (character == CHAR_NEWLINE) || (col_inc == (COL_W+1)'(COLS));
    scroll   = wrap && (row_inc == (ROW_W+1)'(ROWS));
  end

  // Next state, memory request and result
  always_comb begin
    state_next     = state;
    cur_col_next   = cur_col;
    cur_row_next   = cur_row;
    top_next       = top;
    cnt_next       = cnt;
    fill_addr_next = fill_addr;
    rd_ok_next     = rd_ok;
    req            = '0;
    res            = '0;
    res.cursor_column = 7'(cur_col);
    res.cursor_row    = 5'(cur_row);

    unique case (state)
      ST_CLEAR: begin
        req.we    = 1'b1;
        req.addr  = cnt;
        req.wdata = CELL_RESET;
        cnt_next  = cnt + 1'b1;
        if (cnt == ADDR_W'(CELLS - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          res.load = 1'b1;
          unique case (mode)
            MODE_PUT_CHAR: begin
              if (character != CHAR_NEWLINE) begin
                req.we    = 1'b1;
                req.addr  = cur_addr;
                req.wdata = {text_color, character};
              end
              cur_col_next = wrap ? '0 : col_inc[COL_W-1:0];
              cur_row_next = wrap ? row_inc[ROW_W-1:0] : cur_row;
              if (scroll) begin
                // Old top row becomes the new bottom row
                cur_row_next   = ROW_W'(ROWS - 1);
                top_next       = (top == ROW_W'(ROWS - 1)) ? '0 : top + 1'b1;
                fill_addr_next = cell_addr(top, '0);
                cnt_next       = '0;
                res.load       = 1'b0;
                state_next     = ST_FILL;
              end
            end
            MODE_PUT_ENTRY: begin
              req.we    = xy_ok;
              req.addr  = xy_addr;
              req.wdata = {entry_color, character};
            end
            MODE_MARKER: begin
              req.we    = 1'b1;
              req.addr  = cur_addr;
              req.wdata = show ? {ATTR_LIGHT_BLUE, CHAR_MARK} : {ATTR_WHITE, CHAR_SPACE};
            end
            MODE_READ: begin
              req.re     = xy_ok;
              req.addr   = xy_addr;
              rd_ok_next = xy_ok;
              res.load   = 1'b0;
              state_next = ST_READ;
            end
            default: ;
          endcase
          res.cursor_column = 7'(cur_col_next);
          res.cursor_row    = 5'(cur_row_next);
        end
      end
      ST_READ: begin
        // Read data is valid this cycle
        res.load   = 1'b1;
        res.use_rd = rd_ok;
        state_next = ST_IDLE;
      end
      ST_FILL: begin
        req.we    = 1'b1;
        req.addr  = fill_addr + cnt;
        req.wdata = {text_color, CHAR_SPACE};
        cnt_next  = cnt + 1'b1;
        if (cnt == ADDR_W'(COLS - 1)) begin
          cnt_next       = '0;
          res.load       = 1'b1;
          res.did_scroll = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold state, cursor, offset, fill base and color
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cur_col    <= '0;
      cur_row    <= '0;
      top        <= '0;
      cnt        <= '0;
      fill_addr  <= '0;
      rd_ok      <= 1'b0;
      text_color <= COLOR_RESET;
    end else begin
      state     <= state_next;
      cur_col   <= cur_col_next;
      cur_row   <= cur_row_next;
      top       <= top_next;
      cnt       <= cnt_next;
      fill_addr <= fill_addr_next;
      rd_ok     <= rd_ok_next;
      if (cfg_wen) begin
        text_color <= cfg_wdata;
      end
    end
  end

endmodule

// ----- src/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer: text-mode character cell engine
// Cell store with cursor, circular scrolling and cell read-back.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_ stream (mode in s_tuser, operands in s_tdata).
//   Each transaction yields exactly one result on the m_ stream carrying the
//   read cell, the cursor after the command and a scroll flag.
//   cfg_wen/cfg_wdata set the text color used by put-char and scroll fill.
// Timing:
//   Cell writes and cursor moves happen on acceptance; the result is
//   registered and appears the cycle after acceptance.
//   A cell read passes through ST_READ, as the cell memory port is registered.
//   A put-char that scrolls then fills in ST_FILL: the new bottom row is
//   written one cell per cycle through the single memory port.
// Reset:
//   rst (synchronous) clears cursor and offset, sets color 0x07 and starts a
//   sweep writing 0x0720 into all ROWS*COLS cells; s_tready stays low
//   during the sweep.
// Stall:
//   One result is buffered in the output register; a new command is taken
//   while it is drained, otherwise s_tready drops until m_tready returns.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata,   // text_color
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,     // character, entry_color, col_x, row_y, show
  input  logic [1:0]  s_tuser,     // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata      // read_cell, cursor_column, cursor_row, did_scroll
);
  import tcw_pkg::*;

  mem_req_t    req;
  res_t        res;
  logic [15:0] rdata;
  logic        out_free;

  logic [15:0] read_cell;
  logic [6:0]  cursor_column;
  logic [4:0]  cursor_row;
  logic        did_scroll;

  assign out_free = !m_tvalid || m_tready;

  tcw_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .mode        (s_tuser),
    .character   (s_tdata[7:0]),
    .entry_color (s_tdata[15:8]),
    .col_x       (s_tdata[22:16]),
    .row_y       (s_tdata[27:23]),
    .show        (s_tdata[28]),
    .out_free    (out_free),
    .req         (req),
    .res         (res)
  );

  tcw_cell_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // Track output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Capture result payload
  always_ff @(posedge clk) begin
    if (res.load) begin
      read_cell     <= res.use_rd ? rdata : 16'h0000;
      cursor_column <= res.cursor_column;
      cursor_row    <= res.cursor_row;
      did_scroll    <= res.did_scroll;
    end
  end

  assign m_tdata = {3'b000, did_scroll, cursor_row, cursor_column, read_cell};

endmodule

// ----- bench/tb_text_console_writer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_writer: self-checking bench for the text console writer
// Drives console commands, with a table of directed rows first and random
// command sequences after it. Typed results are checked as given, all others
// against a cycle-free model of the cell store, cursor and scroll offset,
// with random gaps, stalls on both streams, text color changed between phases.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 100;
  localparam int RANDOM_PHASES  = 4;
  localparam int PHASE_ITEMS    = 150;

  // One console command and the result it produces
  typedef struct {
    logic [1:0] mode;
    logic [7:0] ch;
    logic [7:0] ecol;
    logic [6:0] x;
    logic [4:0] y;
    logic       show;
  } console_cmd_t;

  typedef struct {
    logic [15:0] rd_cell;
    logic [6:0]  col;
    logic [4:0]  row;
    logic        scrolled;
  } console_res_t;

  // Directed row: a typed result is used when known is set
  typedef struct {
    console_cmd_t cmd;
    bit           known;
    console_res_t res;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = 32'h0;   // character, entry_color, col_x, row_y, show
  logic [1:0]  s_tuser = 2'b00;   // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // read_cell, cursor_column, cursor_row, did_scroll

  // Model state of the console
  logic [15:0]  screen_mem [CELLS];
  int           pred_col;
  int           pred_row;
  int           pred_top;
  logic [7:0]   pred_color;

  console_res_t  pending_results [$];
  directed_row_t directed_rows [$];
  int            mismatch_count = 0;
  int            results_seen = 0;
  int            idle_cycles = 0;
  bit            sender_idles = 1'b1;

  text_console_writer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Store index of a logical cell, seen through the scroll offset
  function automatic int screen_index(int x, int y);
    return ((pred_top + y) % ROWS) * COLS + x;
  endfunction

  // Apply one command to the model and return its result
  function automatic console_res_t predict_console(console_cmd_t c);
    console_res_t r;
    int k;
    r.rd_cell = 16'h0000;
    r.scrolled = 1'b0;
    case (c.mode)
      MODE_PUT_CHAR: begin
        if (c.ch == CHAR_NEWLINE) begin
          pred_col = 0;
          pred_row++;
        end else begin
          screen_mem[screen_index(pred_col, pred_row)] = {pred_color, c.ch};
          pred_col++;
          if (pred_col >= COLS) begin
            pred_col = 0;
            pred_row++;
          end
        end
        // Past the last row: advance the offset and blank the new bottom row
        if (pred_row >= ROWS) begin
          pred_top = (pred_top + 1) % ROWS;
          for (k = 0; k < COLS; k++) begin
            screen_mem[screen_index(k, ROWS - 1)] = {pred_color, CHAR_SPACE};
          end
          pred_row = ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
      MODE_PUT_ENTRY: begin
        if (c.x < COLS && c.y < ROWS) begin
          screen_mem[screen_index(c.x, c.y)] = {c.ecol, c.ch};
        end
      end
      MODE_MARKER: begin
        if (c.show) begin
          screen_mem[screen_index(pred_col, pred_row)] = {ATTR_LIGHT_BLUE, CHAR_MARK};
        end else begin
          screen_mem[screen_index(pred_col, pred_row)] = {ATTR_WHITE, CHAR_SPACE};
        end
      end
      default: begin
        if (c.x < COLS && c.y < ROWS) begin
          r.rd_cell = screen_mem[screen_index(c.x, c.y)];
        end
      end
    endcase
    r.col = pred_col[6:0];
    r.row = pred_row[4:0];
    return r;
  endfunction

  // Build one directed row
  function automatic directed_row_t table_row(logic [1:0] mode, logic [7:0] ch,
                                              logic [7:0] ecol, logic [6:0] x,
                                              logic [4:0] y, logic show, bit known,
                                              logic [15:0] rd_cell, logic [6:0] col,
                                              logic [4:0] row);
    directed_row_t d;
    d.cmd.mode = mode;
    d.cmd.ch = ch;
    d.cmd.ecol = ecol;
    d.cmd.x = x;
    d.cmd.y = y;
    d.cmd.show = show;
    d.known = known;
    d.res.rd_cell = rd_cell;
    d.res.col = col;
    d.res.row = row;
    d.res.scrolled = 1'b0;
    return d;
  endfunction

  // Offer one command after an optional gap, hold until the transaction
  task automatic send_command(console_cmd_t c, bit known, console_res_t typed);
    int gap;
    console_res_t r;
    gap = sender_idles ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.mode;
    s_tdata  <= {3'b000, c.show, c.y, c.x, c.ecol, c.ch};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    r = predict_console(c);
    pending_results.push_back(known ? typed : r);
  endtask

  // Drain all results, then write the text color while the block is idle
  task automatic set_text_color(logic [7:0] value);
    s_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    pred_color = value;
  endtask

  // Random command with noise in the fields the mode does not use
  function automatic console_cmd_t random_command(logic [1:0] mode);
    console_cmd_t c;
    c.mode = mode;
    c.ch   = 8'($urandom);
    c.ecol = 8'($urandom);
    c.show = 1'($urandom);
    if ($urandom_range(0, 99) < 85) begin
      c.x = 7'($urandom_range(0, COLS - 1));
      c.y = 5'($urandom_range(0, ROWS - 1));
    end else begin
      c.x = 7'($urandom);
      c.y = 5'($urandom);
    end
    return c;
  endfunction

  // Stimulus
  initial begin
    console_cmd_t c;
    console_res_t none;
    int k;
    int sent;
    int run_len;
    int pick;

    for (k = 0; k < CELLS; k++) begin
      screen_mem[k] = CELL_RESET;
    end
    pred_col = 0;
    pred_row = 0;
    pred_top = 0;
    pred_color = COLOR_RESET;
    none = '{16'h0, 7'h0, 5'h0, 1'b0};

    // Hold off until reset is released
    while (rst) @(posedge clk);

    // Directed rows: reset contents, range edges, raw bytes, markers, entries
    directed_rows.push_back(table_row(MODE_READ, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0,
                                      1, CELL_RESET, 7'd0, 5'd0));
    directed_rows.push_back(table_row(MODE_READ, 8'hFF, 8'hFF, 7'd79, 5'd24, 1'b1,
                                      1, CELL_RESET, 7'd0, 5'd0));
    directed_rows.push_back(table_row(MODE_READ, 8'h00, 8'h00, 7'd80, 5'd0, 1'b0,
                                      1, 16'h0000, 7'd0, 5'd0));
    directed_rows.push_back(table_row(MODE_READ, 8'h00, 8'h00, 7'd0, 5'd25, 1'b0,
                                      1, 16'h0000, 7'd0, 5'd0));
    directed_rows.push_back(table_row(MODE_READ, 8'h00, 8'h00, 7'd127, 5'd31, 1'b1,
                                      1, 16'h0000, 7'd0, 5'd0));
    directed_rows.push_back(table_row(MODE_PUT_CHAR, 8'h41, 8'h00, 7'd0, 5'd0, 1'b0,
                                      1, 16'h0000, 7'd1, 5'd0));
    directed_rows.push_back(table_row(MODE_PUT_CHAR, 8'hFF, 8'hFF, 7'd127, 5'd31, 1'b1,
                                      1, 16'h0000, 7'd2, 5'd0));
    directed_rows.push_back(table_row(MODE_PUT_CHAR, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0,
                                      1, 16'h0000, 7'd3, 5'd0));
    directed_rows.push_back(table_row(MODE_READ, 8'h00, 8'h00, 7'd1, 5'd0, 1'b0,
                                      1, 16'h07FF, 7'd3, 5'd0));
    directed_rows.push_back(table_row(MODE_PUT_CHAR, CHAR_NEWLINE, 8'h00, 7'd0, 5'd0,
                                      1'b0, 1, 16'h0000, 7'd0, 5'd1));
    directed_rows.push_back(table_row(MODE_MARKER, 8'h00, 8'h00, 7'd0, 5'd0, 1'b1,
                                      1, 16'h0000, 7'd0, 5'd1));
    directed_rows.push_back(table_row(MODE_READ, 8'h00, 8'h00, 7'd0, 5'd1, 1'b0,
                                      1, {ATTR_LIGHT_BLUE, CHAR_MARK}, 7'd0, 5'd1));
    directed_rows.push_back(table_row(MODE_MARKER, 8'hFF, 8'hFF, 7'd127, 5'd31, 1'b0,
                                      1, 16'h0000, 7'd0, 5'd1));
    directed_rows.push_back(table_row(MODE_READ, 8'h00, 8'h00, 7'd0, 5'd1, 1'b0,
                                      1, {ATTR_WHITE, CHAR_SPACE}, 7'd0, 5'd1));
    directed_rows.push_back(table_row(MODE_PUT_ENTRY, 8'hFF, 8'hFF, 7'd79, 5'd24, 1'b0,
                                      1, 16'h0000, 7'd0, 5'd1));
    directed_rows.push_back(table_row(MODE_READ, 8'h00, 8'h00, 7'd79, 5'd24, 1'b0,
                                      1, 16'hFFFF, 7'd0, 5'd1));
    directed_rows.push_back(table_row(MODE_PUT_ENTRY, 8'h00, 8'h00, 7'd0, 5'd0, 1'b1,
                                      1, 16'h0000, 7'd0, 5'd1));
    directed_rows.push_back(table_row(MODE_READ, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0,
                                      1, 16'h0000, 7'd0, 5'd1));
    // Out-of-range entries must leave the store alone
    directed_rows.push_back(table_row(MODE_PUT_ENTRY, 8'h55, 8'hAA, 7'd80, 5'd3, 1'b0,
                                      0, none.rd_cell, 7'd0, 5'd0));
    directed_rows.push_back(table_row(MODE_PUT_ENTRY, 8'h55, 8'hAA, 7'd5, 5'd25, 1'b0,
                                      0, none.rd_cell, 7'd0, 5'd0));
    directed_rows.push_back(table_row(MODE_PUT_ENTRY, 8'hAA, 8'h55, 7'd127, 5'd31, 1'b1,
                                      0, none.rd_cell, 7'd0, 5'd0));
    directed_rows.push_back(table_row(MODE_READ, 8'h00, 8'h00, 7'd79, 5'd3, 1'b0,
                                      0, none.rd_cell, 7'd0, 5'd0));
    directed_rows.push_back(table_row(MODE_READ, 8'h00, 8'h00, 7'd5, 5'd24, 1'b1,
                                      0, none.rd_cell, 7'd0, 5'd0));
    directed_rows.push_back(table_row(MODE_READ, 8'h00, 8'h00, 7'd2, 5'd0, 1'b0,
                                      0, none.rd_cell, 7'd0, 5'd0));

    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].known, directed_rows[i].res);
    end

    // Random phases, each under its own text color
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_text_color(8'h00);
        1: set_text_color(8'hFF);
        2: set_text_color(8'($urandom));
        default: set_text_color(8'h4E);
      endcase
      sender_idles = (p != 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          // Text run with occasional line breaks
          run_len = $urandom_range(1, 30);
          for (k = 0; k < run_len; k++) begin
            c = random_command(MODE_PUT_CHAR);
            if ($urandom_range(0, 9) == 0) c.ch = CHAR_NEWLINE;
            send_command(c, 0, none);
          end
          sent += run_len;
        end else if (pick < 55) begin
          // Burst of line breaks to push the screen into scrolling
          run_len = $urandom_range(1, 30);
          for (k = 0; k < run_len; k++) begin
            c = random_command(MODE_PUT_CHAR);
            c.ch = CHAR_NEWLINE;
            send_command(c, 0, none);
          end
          sent += run_len;
        end else begin
          if (pick < 70) c = random_command(MODE_PUT_ENTRY);
          else if (pick < 80) c = random_command(MODE_MARKER);
          else c = random_command(MODE_READ);
          send_command(c, 0, none);
          sent++;
        end
      end
    end

    // Drain and let the block settle
    s_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Compare one result field
  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: check each transaction, stall at random, hold off once
  initial begin
    console_res_t want;
    int stall_left;
    bit pressure_done;
    stall_left = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid === 1'b1 && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("read_cell", want.rd_cell, m_tdata[15:0]);
          check_field("cursor_column", want.col, m_tdata[22:16]);
          check_field("cursor_row", want.row, m_tdata[27:23]);
          check_field("did_scroll", want.scrolled, m_tdata[28]);
        end
        results_seen++;
        // Long hold-off so the block fills up and stalls its input
        if (results_seen == 150 && !pressure_done) begin
          stall_left = 400;
          pressure_done = 1'b1;
        end
      end
      if (stall_left == 0 && ((results_seen / 120) % 3) != 1) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
